[hdl/mld_pkg.sv]
`default_nettype none

package mld_pkg;

   // Characters of interest
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;

   // Result status codes
   localparam logic [1:0] STATUS_LETTER    = 2'd0;
   localparam logic [1:0] STATUS_NOT_MORSE = 2'd1;
   localparam logic [1:0] STATUS_END_ONLY  = 2'd2;

   localparam int unsigned NUM_LETTERS  = 26;
   localparam logic [2:0]  MAX_SYMBOLS  = 3'd4;
   localparam logic [2:0]  SAT_COUNT    = 3'd5;
   localparam logic [6:0]  LETTER_BASE  = 7'd65;

   // Code length and pattern for A..Z; bit i of a pattern is symbol i, 1 = dash
   localparam logic [2:0] CODE_LEN [NUM_LETTERS] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
   };
   localparam logic [3:0] CODE_BITS [NUM_LETTERS] = '{
      4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
      4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
   };

   typedef struct packed {
      logic [7:0] text_char;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [6:0] letter;
      logic [1:0] status;
      logic       last_of_message;
   } rsp_type;

   // Token that closes with the current word
   typedef struct packed {
      logic       emit;
      logic       end_only;
      logic [2:0] count;
      logic [3:0] pattern;
      logic       invalid;
      logic       last;
   } fin_type;

   function automatic logic is_separator(input logic [7:0] c);
      is_separator = (c == CHAR_SPACE) || (c == CHAR_TAB) ||
                     (c == CHAR_LF) || (c == CHAR_CR);
   endfunction

endpackage

`default_nettype wire

[hdl/mld_token.sv]
`default_nettype none

module mld_token
   import mld_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    item_fire,
   input  wire req_type item,
   output fin_type      fin
);

   logic [2:0] count_ff, count_in;
   logic [3:0] pattern_ff, pattern_in;
   logic       invalid_ff, invalid_in;

   logic [2:0] upd_count;
   logic [3:0] upd_pattern;
   logic       upd_invalid;
   logic       sep;
   logic       symbol;
   logic       pending;

   always_comb begin
      sep         = is_separator(item.text_char);
      symbol      = (item.text_char == CHAR_DOT) || (item.text_char == CHAR_DASH);
      pending     = (count_ff != 3'd0) || invalid_ff;
      upd_count   = count_ff;
      upd_pattern = pattern_ff;
      upd_invalid = invalid_ff;
      if (symbol) begin
         if (count_ff < MAX_SYMBOLS) begin
            if (item.text_char == CHAR_DASH) begin
               upd_pattern[count_ff[1:0]] = 1'b1;
            end
            upd_count = count_ff + 3'd1;
         end else begin
            upd_count = SAT_COUNT;
         end
      end else if (!sep) begin
         upd_invalid = 1'b1;
      end

      fin.last = item.end_of_message;
      if (sep) begin
         fin.emit     = pending || item.end_of_message;
         fin.end_only = !pending;
         fin.count    = count_ff;
         fin.pattern  = pattern_ff;
         fin.invalid  = invalid_ff;
      end else begin
         fin.emit     = item.end_of_message;
         fin.end_only = 1'b0;
         fin.count    = upd_count;
         fin.pattern  = upd_pattern;
         fin.invalid  = upd_invalid;
      end

      count_in   = count_ff;
      pattern_in = pattern_ff;
      invalid_in = invalid_ff;
      if (item_fire) begin
         // clear whenever a result goes out, else keep collecting
         if (sep || item.end_of_message) begin
            count_in   = 3'd0;
            pattern_in = 4'd0;
            invalid_in = 1'b0;
         end else begin
            count_in   = upd_count;
            pattern_in = upd_pattern;
            invalid_in = upd_invalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 3'd0;
         pattern_ff <= 4'd0;
         invalid_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         pattern_ff <= pattern_in;
         invalid_ff <= invalid_in;
      end
   end

   count_range_a: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SAT_COUNT)
      else $error("symbol count out of range");

   pattern_bound_a: assert property (@(posedge clock) disable iff (reset)
      (count_ff < MAX_SYMBOLS) |-> ((pattern_ff >> count_ff) == 4'd0))
      else $error("pattern bit set beyond symbol count");

   clear_after_end_a: assert property (@(posedge clock) disable iff (reset)
      (item_fire && item.end_of_message) |=> (count_ff == 3'd0 && !invalid_ff))
      else $error("token not cleared after end of message");

endmodule

`default_nettype wire

[hdl/mld_match.sv]
`default_nettype none

module mld_match
   import mld_pkg::*;
(
   input  wire fin_type fin,
   output rsp_type      result
);

   logic       hit;
   logic [4:0] index;

   always_comb begin
      hit   = 1'b0;
      index = 5'd0;
      for (int i = 0; i < NUM_LETTERS; i++) begin
         if (CODE_LEN[i] == fin.count && CODE_BITS[i] == fin.pattern) begin
            hit   = 1'b1;
            index = 5'(i);
         end
      end

      result.last_of_message = fin.last;
      if (fin.end_only) begin
         result.letter = 7'd0;
         result.status = STATUS_END_ONLY;
      end else if (hit && !fin.invalid) begin
         result.letter = LETTER_BASE + {2'b00, index};
         result.status = STATUS_LETTER;
      end else begin
         result.letter = 7'd0;
         result.status = STATUS_NOT_MORSE;
      end
   end

endmodule

`default_nettype wire

[hdl/morse_letter_decoder_unit.sv]
`default_nettype none

// Morse letter decoder: takes one text character per cycle while rsp_ready does not hold
// it back, and returns at most one result word per character. Dots and dashes build a
// token; a separator (space, tab, CR, LF) or a character flagged end_of_message closes
// it, and the token is matched against the codes for A..Z. A result carries the ASCII
// letter with status 0, status 1 for a token that is not a letter code, or status 2 for
// an end of message with no token pending. A character passes through the input register
// and then the result register before its result appears on rsp_.
// Back-pressure on rsp_ready stalls the input side once both registers are full.
module morse_letter_decoder_unit
   import mld_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   req_type req_ff;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;

   fin_type fin;
   rsp_type result;
   logic    can_advance;
   logic    fire;
   logic    req_take;

   assign can_advance = !rsp_valid_ff || rsp_ready;
   assign fire        = req_valid_ff && can_advance;
   assign req_ready   = !req_valid_ff || can_advance;
   assign req_take    = req_valid && req_ready;

   mld_token u_token (
      .clock     (clock),
      .reset     (reset),
      .item_fire (fire),
      .item      (req_ff),
      .fin       (fin)
   );

   mld_match u_match (
      .fin    (fin),
      .result (result)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (fire) begin
         req_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fire && fin.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         req_ff <= req_payload;
      end
      // hold the result word until it is taken
      if (fire && fin.emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   letter_range_a: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == STATUS_LETTER) |->
      (rsp_payload.letter >= LETTER_BASE && rsp_payload.letter <= 7'd90))
      else $error("decoded letter outside A..Z");

   status_letter_a: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != STATUS_LETTER) |-> (rsp_payload.letter == 7'd0))
      else $error("letter set on a non-letter status");

   end_only_last_a: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == STATUS_END_ONLY) |-> rsp_payload.last_of_message)
      else $error("end-only status without end of message");

   status_code_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == STATUS_LETTER ||
                     rsp_payload.status == STATUS_NOT_MORSE ||
                     rsp_payload.status == STATUS_END_ONLY))
      else $error("undefined status code");

endmodule

`default_nettype wire
